@@ src/sirf_pkg.sv @@
// shared constants, types and codes of the signed integer radix formatter
package sirf_pkg;

  // sizing
  localparam int MAX_SYMBOLS  = 128;
  localparam int NUMBER_BITS  = 32;
  localparam int SYM_W        = 8;
  localparam int CNT_W        = $clog2(MAX_SYMBOLS + 1);
  localparam int SYM_IDX_W    = $clog2(MAX_SYMBOLS);
  localparam int DIG_W        = SYM_IDX_W;
  localparam int REM_W        = CNT_W;
  localparam int ND_W         = $clog2(NUMBER_BITS + 1);
  localparam int DBUF_IDX_W   = $clog2(NUMBER_BITS);
  localparam int BIT_CNT_W    = $clog2(NUMBER_BITS);
  localparam int PRESENT_W    = 128;
  localparam int PRESENT_IDX_W = $clog2(PRESENT_W);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // input mode codes
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_FORMAT = 2'd2;

  // character constants
  localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CHAR_LOW   = 8'd32;
  localparam logic [SYM_W-1:0] CHAR_HIGH  = 8'd126;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_FORMAT
  } op_e;

  // one classified command as it sits in the queue
  typedef struct packed {
    op_e                    op;
    logic [SYM_W-1:0]       symbol;
    logic                   sym_ok;
    logic                   neg;
    logic [NUMBER_BITS-1:0] mag;
  } item_t;

  // queue to back end handshake
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

@@ src/sirf_if.sv @@
// valid/ready channel interfaces for command words and character words
interface sirf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [7:0]         symbol;
  logic signed [31:0] number;

  modport source (output valid, output mode, output symbol, output number, input ready);
  modport sink   (input valid, input mode, input symbol, input number, output ready);
endinterface

interface sirf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, output char_out, output last, input ready);
  modport sink   (input valid, input char_out, input last, output ready);
endinterface

@@ src/signed_integer_radix_formatter.sv @@
// top level of the signed integer radix formatter
//
// usage
//   in_i carries command words: mode clear empties the digit alphabet, mode
//   append adds one symbol byte, mode format turns a signed 32-bit number into
//   text; mode 3 words are taken and dropped
//   out_o carries the character words, each held until taken: '-' for a
//   negative number, then the digits most significant first, last on the end
//   a bad alphabet or one with fewer than two symbols yields no words
// flow
//   clear and append update the alphabet registers as they leave the queue
//   format runs each digit through the bit-serial divider, then per character
//   reads the digit buffer (ST_RDDIG) and the symbol table (ST_RDSYM) and
//   emits the character in ST_EMIT, which waits on a stalled receiver
// reset
//   alphabet empty and good, queue and output register empty
// stall
//   a stalled receiver holds the output register; the back end waits on it,
//   the two-entry queue fills and then in_i.ready drops
module signed_integer_radix_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  sirf_in_if.sink     in_i,
  sirf_out_if.source  out_o
);

  sirf_pkg::item_t   push_item;
  sirf_pkg::q_head_t head;
  logic              push, full, pop;

  // classify and take magnitude
  sirf_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  // decouples intake from the slow divider
  sirf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  // alphabet, divider and character output
  sirf_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

@@ src/sirf_front.sv @@
// front end: takes command words, classifies them and pushes them to the queue
module sirf_front (
  sirf_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output sirf_pkg::item_t item_o
);

  logic keep;

  assign in_i.ready = !full_i;

  always_comb begin
    keep        = 1'b1;
    item_o.op   = sirf_pkg::OP_CLEAR;
    unique case (in_i.mode)
      sirf_pkg::MODE_CLEAR:  item_o.op = sirf_pkg::OP_CLEAR;
      sirf_pkg::MODE_APPEND: item_o.op = sirf_pkg::OP_APPEND;
      sirf_pkg::MODE_FORMAT: item_o.op = sirf_pkg::OP_FORMAT;
      default:               keep      = 1'b0;
    endcase
    item_o.symbol = in_i.symbol;
    // printable, and not a sign character
    item_o.sym_ok = (in_i.symbol != sirf_pkg::CHAR_PLUS) &&
                    (in_i.symbol != sirf_pkg::CHAR_MINUS) &&
                    (in_i.symbol >= sirf_pkg::CHAR_LOW) &&
                    (in_i.symbol <= sirf_pkg::CHAR_HIGH);
    item_o.neg = in_i.number[sirf_pkg::NUMBER_BITS-1];
    // most negative value wraps to its own unsigned magnitude
    item_o.mag = item_o.neg ? (~in_i.number + 1'b1) : in_i.number;
  end

  assign push_o = in_i.valid && !full_i && keep;

endmodule

@@ src/sirf_fifo.sv @@
// short queue between front and back end
module sirf_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sirf_pkg::item_t   item_i,
  output logic              full_o,
  output sirf_pkg::q_head_t head_o,
  input  logic              pop_i
);

  sirf_pkg::item_t                   mem_q [sirf_pkg::QUEUE_DEPTH];
  logic [sirf_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [sirf_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              do_push, do_pop;

  assign full_o       = (cnt_q == sirf_pkg::QCNT_W'(sirf_pkg::QUEUE_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == sirf_pkg::QPTR_W'(sirf_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == sirf_pkg::QPTR_W'(sirf_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ src/sirf_back.sv @@
// back end: alphabet upkeep, digit-by-digit division and character output
module sirf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sirf_pkg::q_head_t head_i,
  output logic              pop_o,
  sirf_out_if.source        out_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_SIGN  = 3'd2;
  localparam logic [2:0] ST_RDDIG = 3'd3;
  localparam logic [2:0] ST_RDSYM = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]                         state_q, state_d;
  logic [sirf_pkg::CNT_W-1:0]         count_q, count_d;
  logic                               bad_q, bad_d;
  logic [sirf_pkg::PRESENT_W-1:0]     present_q, present_d;
  logic [sirf_pkg::NUMBER_BITS-1:0]   quo_q, quo_d;
  logic [sirf_pkg::REM_W-1:0]         rem_q, rem_d;
  logic [sirf_pkg::BIT_CNT_W-1:0]     bit_q, bit_d;
  logic [sirf_pkg::ND_W-1:0]          nd_q, nd_d;
  logic                               neg_q, neg_d;
  logic                               out_valid_q, out_valid_d;
  logic [sirf_pkg::SYM_W-1:0]         out_char_q, out_char_d;
  logic                               out_last_q, out_last_d;

  // memories
  logic [sirf_pkg::SYM_W-1:0]         sym_tab [sirf_pkg::MAX_SYMBOLS];
  logic [sirf_pkg::DIG_W-1:0]         dig_buf [sirf_pkg::NUMBER_BITS];
  logic [sirf_pkg::SYM_W-1:0]         sym_rd_q;
  logic [sirf_pkg::DIG_W-1:0]         dig_rd_q;
  logic                               tab_we, dbuf_we;
  logic [sirf_pkg::ND_W-1:0]          nd_prev;

  // divider step
  logic [sirf_pkg::REM_W:0]           trial;
  logic                               ge;
  logic [sirf_pkg::REM_W:0]           diff;
  logic [sirf_pkg::REM_W-1:0]         rem_step;
  logic [sirf_pkg::NUMBER_BITS-1:0]   quo_step;
  logic                               out_free, dup;

  assign trial    = {rem_q, quo_q[sirf_pkg::NUMBER_BITS-1]};
  assign ge       = (trial >= {1'b0, count_q});
  assign diff     = trial - {1'b0, count_q};
  assign rem_step = ge ? diff[sirf_pkg::REM_W-1:0] : trial[sirf_pkg::REM_W-1:0];
  assign quo_step = {quo_q[sirf_pkg::NUMBER_BITS-2:0], ge};
  assign out_free = !out_valid_q || out_o.ready;
  assign nd_prev  = nd_q - 1'b1;
  assign dup      = present_q[head_i.item.symbol[sirf_pkg::PRESENT_IDX_W-1:0]];
  assign pop_o    = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    bad_d       = bad_q;
    present_d   = present_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    nd_d        = nd_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    tab_we      = 1'b0;
    dbuf_we     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (head_i.valid) begin
          unique case (head_i.item.op)
            sirf_pkg::OP_CLEAR: begin
              count_d   = '0;
              bad_d     = 1'b0;
              present_d = '0;
            end
            sirf_pkg::OP_APPEND: begin
              if (!head_i.item.sym_ok || dup ||
                  (count_q >= sirf_pkg::CNT_W'(sirf_pkg::MAX_SYMBOLS))) begin
                bad_d = 1'b1;
              end else begin
                tab_we = 1'b1;
                count_d = count_q + 1'b1;
                present_d[head_i.item.symbol[sirf_pkg::PRESENT_IDX_W-1:0]] = 1'b1;
              end
            end
            sirf_pkg::OP_FORMAT: begin
              if (!bad_q && (count_q >= sirf_pkg::CNT_W'(2))) begin
                quo_d   = head_i.item.mag;
                neg_d   = head_i.item.neg;
                rem_d   = '0;
                bit_d   = '0;
                nd_d    = '0;
                state_d = ST_DIV;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        quo_d = quo_step;
        rem_d = rem_step;
        bit_d = bit_q + 1'b1;
        if (bit_q == sirf_pkg::BIT_CNT_W'(sirf_pkg::NUMBER_BITS - 1)) begin
          // one digit done: keep remainder, divide the quotient again
          dbuf_we = 1'b1;
          nd_d    = nd_q + 1'b1;
          rem_d   = '0;
          if (quo_step == '0) begin
            state_d = neg_q ? ST_SIGN : ST_RDDIG;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sirf_pkg::CHAR_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_RDDIG;
        end
      end
      ST_RDDIG: begin
        state_d = ST_RDSYM;
      end
      ST_RDSYM: begin
        nd_d    = nd_prev;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = sym_rd_q;
          out_last_d  = (nd_q == '0);
          state_d     = (nd_q == '0) ? ST_IDLE : ST_RDDIG;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      bad_q       <= 1'b0;
      present_q   <= '0;
      bit_q       <= '0;
      nd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bad_q       <= bad_d;
      present_q   <= present_d;
      bit_q       <= bit_d;
      nd_q        <= nd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // symbol table, registered read held while the character waits
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      sym_tab[count_q[sirf_pkg::SYM_IDX_W-1:0]] <= head_i.item.symbol;
    end
    if (state_q == ST_RDSYM) begin
      sym_rd_q <= sym_tab[dig_rd_q];
    end
  end

  // digit buffer, registered read
  always_ff @(posedge clk_i) begin
    if (dbuf_we) begin
      dig_buf[nd_q[sirf_pkg::DBUF_IDX_W-1:0]] <= rem_step[sirf_pkg::DIG_W-1:0];
    end
    dig_rd_q <= dig_buf[nd_prev[sirf_pkg::DBUF_IDX_W-1:0]];
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.char_out = out_char_q;
  assign out_o.last     = out_last_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sirf_pkg::CNT_W'(sirf_pkg::MAX_SYMBOLS))
    else $error("symbol count beyond capacity");

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < count_q))
    else $error("division remainder not below radix");

  a_digits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nd_q <= sirf_pkg::ND_W'(sirf_pkg::NUMBER_BITS))
    else $error("digit count beyond number width");

  a_last_ends_format: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && nd_q == '0) |=>
      (state_q == ST_IDLE && out_o.valid && out_o.last))
    else $error("final digit did not close the format request");

endmodule
